[rtl/url_percent_encoder_assert.svh]
// Assertion macros used by the encoder RTL.
`ifndef URL_PERCENT_ENCODER_ASSERT_SVH
`define URL_PERCENT_ENCODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UPE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("upe assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define UPE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("upe assertion failed");

`endif

[rtl/upe_pkg.sv]
package upe_pkg;

  // Longest encoded run and the index width that addresses it.
  localparam int unsigned RunMax = 6;
  localparam int unsigned IdxW   = 3;

  // Character codes used in the encoded output.
  localparam logic [7:0] CharPct   = 8'h25;
  localparam logic [7:0] CharTwo   = 8'h32;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTilde = 8'h7E;
  localparam logic [7:0] CharBang  = 8'h21;
  localparam logic [7:0] CharStar  = 8'h2A;
  localparam logic [7:0] CharLPar  = 8'h28;
  localparam logic [7:0] CharRPar  = 8'h29;
  localparam logic [7:0] CharQuote = 8'h27;

  // Character class bounds and hex digit bases.
  localparam logic [7:0] DigitLo       = 8'd48;
  localparam logic [7:0] DigitHi       = 8'd57;
  localparam logic [7:0] UpperLo       = 8'd65;
  localparam logic [7:0] UpperHi       = 8'd90;
  localparam logic [7:0] LowerLo       = 8'd97;
  localparam logic [7:0] LowerHi       = 8'd122;
  localparam logic [7:0] HexLowerBase  = 8'd87;  // 'a' - 10
  localparam logic [7:0] HexUpperBase  = 8'd55;  // 'A' - 10

  // One encoded run: bytes in transfer order and the index of the final byte.
  typedef struct packed {
    logic [RunMax-1:0][7:0] data;
    logic [IdxW-1:0]        last_idx;
  } run_t;

  // Result of the accented-letter lookup: UTF-8 lead and trail bytes.
  typedef struct packed {
    logic       hit;
    logic [7:0] lead;
    logic [7:0] trail;
  } accent_t;

  // Maps an ISO-8859-2 accented letter to its two-byte UTF-8 form.
  function automatic accent_t accent_lookup(logic [7:0] b);
    accent_t r;
    r.hit = 1'b1;
    unique case (b)
      8'hE1: begin r.lead = 8'hC3; r.trail = 8'hA1; end
      8'hC1: begin r.lead = 8'hC3; r.trail = 8'h81; end
      8'hE4: begin r.lead = 8'hC3; r.trail = 8'hA4; end
      8'hC4: begin r.lead = 8'hC3; r.trail = 8'h84; end
      8'hE9: begin r.lead = 8'hC3; r.trail = 8'hA9; end
      8'hC9: begin r.lead = 8'hC3; r.trail = 8'h89; end
      8'hED: begin r.lead = 8'hC3; r.trail = 8'hAD; end
      8'hCD: begin r.lead = 8'hC3; r.trail = 8'h8D; end
      8'hF3: begin r.lead = 8'hC3; r.trail = 8'hB3; end
      8'hD3: begin r.lead = 8'hC3; r.trail = 8'h93; end
      8'hF6: begin r.lead = 8'hC3; r.trail = 8'hB6; end
      8'hD6: begin r.lead = 8'hC3; r.trail = 8'h96; end
      8'hF5: begin r.lead = 8'hC5; r.trail = 8'h91; end
      8'hD5: begin r.lead = 8'hC5; r.trail = 8'h90; end
      8'hFC: begin r.lead = 8'hC3; r.trail = 8'hBC; end
      8'hDC: begin r.lead = 8'hC3; r.trail = 8'h9C; end
      8'hFB: begin r.lead = 8'hC5; r.trail = 8'hB1; end
      8'hDB: begin r.lead = 8'hC5; r.trail = 8'hB0; end
      8'hFA: begin r.lead = 8'hC3; r.trail = 8'hBA; end
      8'hDA: begin r.lead = 8'hC3; r.trail = 8'h9A; end
      default: begin r.hit = 1'b0; r.lead = 8'h00; r.trail = 8'h00; end
    endcase
    return r;
  endfunction

  // ASCII hex digit for one nibble, in upper or lower case.
  function automatic logic [7:0] hex_digit(logic [3:0] nib, logic upper);
    logic [7:0] base;
    if (nib <= 4'd9) begin
      base = DigitLo;
    end else begin
      base = upper ? HexUpperBase : HexLowerBase;
    end
    return base + {4'd0, nib};
  endfunction

endpackage

[rtl/upe_in_if.sv]
interface upe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

[rtl/upe_out_if.sv]
interface upe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

[rtl/upe_encode.sv]
module upe_encode
  import upe_pkg::*;
(
  input  logic [7:0] byte_i,
  output run_t       run_o
);

  accent_t acc;
  logic    pass;

  assign acc = accent_lookup(byte_i);

  // Letters, digits and the unreserved marks go out unchanged.
  always_comb begin
    pass = ((byte_i >= DigitLo) && (byte_i <= DigitHi)) ||
           ((byte_i >= UpperLo) && (byte_i <= UpperHi)) ||
           ((byte_i >= LowerLo) && (byte_i <= LowerHi)) ||
           (byte_i == CharTilde) || (byte_i == CharBang) ||
           (byte_i == CharStar)  || (byte_i == CharLPar) ||
           (byte_i == CharRPar)  || (byte_i == CharQuote);
  end

  // Build the whole run; unused slots are zero.
  always_comb begin
    run_o.data     = '0;
    run_o.last_idx = '0;
    priority if (acc.hit) begin
      run_o.data[0]  = CharPct;
      run_o.data[1]  = hex_digit(acc.lead[7:4], 1'b1);
      run_o.data[2]  = hex_digit(acc.lead[3:0], 1'b1);
      run_o.data[3]  = CharPct;
      run_o.data[4]  = hex_digit(acc.trail[7:4], 1'b1);
      run_o.data[5]  = hex_digit(acc.trail[3:0], 1'b1);
      run_o.last_idx = IdxW'(RunMax - 1);
    end else if (byte_i == CharSpace) begin
      run_o.data[0]  = CharPct;
      run_o.data[1]  = CharTwo;
      run_o.data[2]  = CharZero;
      run_o.last_idx = IdxW'(2);
    end else if (pass) begin
      run_o.data[0]  = byte_i;
      run_o.last_idx = '0;
    end else begin
      run_o.data[0]  = CharPct;
      run_o.data[1]  = hex_digit(byte_i[7:4], 1'b0);
      run_o.data[2]  = hex_digit(byte_i[3:0], 1'b0);
      run_o.last_idx = IdxW'(2);
    end
  end

endmodule

[rtl/url_percent_encoder.sv]
// URL percent encoder.
// in_i carries one source byte per transfer (ISO-8859-2 for accented letters).
// out_o carries the encoded run for that byte, one byte per transfer, with
// last_of_run set on the final byte. A run is 1 byte (pass-through), 3 bytes
// (space or escaped byte) or 6 bytes (an accented letter's two UTF-8 bytes,
// each escaped). The first byte of a run is offered the cycle after the input
// transfer. Pass-through bytes are taken one input byte per cycle while the
// receiver is ready; a longer run holds off the next input byte until its
// final byte leaves, as the single run register feeds the output one byte per
// cycle while out_o.ready is high. A new input is taken in the same cycle as
// the final byte of the previous run leaves, so back-to-back runs have no gap.
// When the receiver stalls, the current byte holds and in_i.ready drops
// until the final byte of the run has been transferred.
// Reset clears the run occupancy and byte pointer; no byte is offered until the next input.
// The block keeps no state between runs.
`include "url_percent_encoder_assert.svh"

module url_percent_encoder
  import upe_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  upe_in_if.sink     in_i,
  upe_out_if.source  out_o
);

  run_t            enc_run;
  run_t            run_q;
  logic            valid_q, valid_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            run_last;
  logic            in_fire;
  logic            out_fire;

  upe_encode u_encode (
    .byte_i (in_i.in_byte),
    .run_o  (enc_run)
  );

  // Handshakes; a new item enters as the last byte of the previous one leaves.
  assign run_last    = (idx_q == run_q.last_idx);
  assign out_fire    = out_o.valid && out_o.ready;
  assign in_i.ready  = !valid_q || (out_o.ready && run_last);
  assign in_fire     = in_i.valid && in_i.ready;

  assign out_o.valid       = valid_q;
  assign out_o.out_byte    = run_q.data[idx_q];
  assign out_o.last_of_run = run_last;

  // Control: run occupancy and byte pointer.
  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    priority if (in_fire) begin
      valid_d = 1'b1;
      idx_d   = '0;
    end else if (out_fire && run_last) begin
      valid_d = 1'b0;
    end else if (out_fire) begin
      idx_d = idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  // Run payload is loaded on each input transfer.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      run_q <= enc_run;
    end
  end

  // The pointer never runs past the final byte of the run.
  `UPE_ASSERT_NOW(a_idx_in_run, clk_i, rst_ni, valid_q, idx_q <= run_q.last_idx)
  // An input transfer during a run only happens as that run's last byte leaves.
  `UPE_ASSERT_NOW(a_in_at_end, clk_i, rst_ni, in_fire && valid_q, out_fire && run_last)
  // A byte that is not the last is followed by the next byte of the same run.
  `UPE_ASSERT_NEXT(a_step, clk_i, rst_ni, out_fire && !run_last,
                   valid_q && (idx_q == $past(idx_q) + IdxW'(1)))
  // A stalled run keeps its position.
  `UPE_ASSERT_NEXT(a_hold, clk_i, rst_ni, valid_q && !out_o.ready,
                   valid_q && $stable(idx_q))

endmodule

[tb/url_percent_encoder_tb.sv]
module url_percent_encoder_tb;
  import upe_pkg::*;

  // One encoded byte as it should leave the block.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } enc_byte_t;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned SettleCycles = 10;

  logic clk_i;
  logic rst_ni;

  upe_in_if  src_ch();
  upe_out_if enc_ch();

  url_percent_encoder uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (src_ch),
    .out_o (enc_ch)
  );

  enc_byte_t   pending_enc[$];
  int unsigned error_count = 0;
  int unsigned src_count = 0;
  int unsigned accent_count = 0;
  int unsigned enc_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // UTF-8 form of the Hungarian accented letters; bit 16 flags a hit.
  function automatic logic [16:0] utf8_of(logic [7:0] b);
    case (b)
      8'hE1: return {1'b1, 16'hC3A1};
      8'hC1: return {1'b1, 16'hC381};
      8'hE4: return {1'b1, 16'hC3A4};
      8'hC4: return {1'b1, 16'hC384};
      8'hE9: return {1'b1, 16'hC3A9};
      8'hC9: return {1'b1, 16'hC389};
      8'hED: return {1'b1, 16'hC3AD};
      8'hCD: return {1'b1, 16'hC38D};
      8'hF3: return {1'b1, 16'hC3B3};
      8'hD3: return {1'b1, 16'hC393};
      8'hF6: return {1'b1, 16'hC3B6};
      8'hD6: return {1'b1, 16'hC396};
      8'hF5: return {1'b1, 16'hC591};
      8'hD5: return {1'b1, 16'hC590};
      8'hFC: return {1'b1, 16'hC3BC};
      8'hDC: return {1'b1, 16'hC39C};
      8'hFB: return {1'b1, 16'hC5B1};
      8'hDB: return {1'b1, 16'hC5B0};
      8'hFA: return {1'b1, 16'hC3BA};
      8'hDA: return {1'b1, 16'hC39A};
      default: return 17'd0;
    endcase
  endfunction

  // Letters, digits and the marks ~ ! * ( ) ' are left as they are.
  function automatic bit is_unreserved(logic [7:0] b);
    return (b >= DigitLo && b <= DigitHi) || (b >= UpperLo && b <= UpperHi) ||
           (b >= LowerLo && b <= LowerHi) || b == CharTilde || b == CharBang ||
           b == CharStar || b == CharLPar || b == CharRPar || b == CharQuote;
  endfunction

  // ASCII character for one hex nibble.
  function automatic logic [7:0] nibble_char(logic [3:0] nib, bit upper);
    if (nib < 4'd10) return DigitLo + nib;
    return (upper ? UpperLo : LowerLo) + nib - 8'd10;
  endfunction

  // Appends one expected byte at the tail of the queue.
  function automatic void expect_enc(logic [7:0] d, bit is_last);
    pending_enc.insert(pending_enc.size(), '{data: d, last: is_last});
  endfunction

  function automatic void push_escape(logic [7:0] v, bit upper, bit last);
    expect_enc(CharPct, 1'b0);
    expect_enc(nibble_char(v[7:4], upper), 1'b0);
    expect_enc(nibble_char(v[3:0], upper), last);
  endfunction

  // Queues the encoded run expected for one source byte.
  function automatic void queue_encoding(logic [7:0] b);
    logic [16:0] utf;
    utf = utf8_of(b);
    if (utf[16]) begin
      push_escape(utf[15:8], 1'b1, 1'b0);
      push_escape(utf[7:0], 1'b1, 1'b1);
    end else if (b == CharSpace) begin
      expect_enc(CharPct, 1'b0);
      expect_enc(CharTwo, 1'b0);
      expect_enc(CharZero, 1'b1);
    end else if (is_unreserved(b)) begin
      expect_enc(b, 1'b1);
    end else begin
      push_escape(b, 1'b0, 1'b1);
    end
  endfunction

  // Source bytes weighted toward accented letters, plain text and spaces.
  function automatic logic [7:0] random_source_byte();
    logic [7:0]  b;
    logic [16:0] utf;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 25) begin
      utf = 17'd0;
      while (!utf[16]) begin
        b = 8'($urandom_range(8'hFC, 8'hC1));
        utf = utf8_of(b);
      end
    end else if (pick < 50) begin
      case ($urandom_range(3))
        0: b = 8'($urandom_range(DigitHi, DigitLo));
        1: b = 8'($urandom_range(UpperHi, UpperLo));
        2: b = 8'($urandom_range(LowerHi, LowerLo));
        default: begin
          case ($urandom_range(5))
            0: b = CharTilde;
            1: b = CharBang;
            2: b = CharStar;
            3: b = CharLPar;
            4: b = CharRPar;
            default: b = CharQuote;
          endcase
        end
      endcase
    end else if (pick < 58) begin
      b = CharSpace;
    end else begin
      b = 8'($urandom_range(255));
    end
    return b;
  endfunction

  // Receiver back-pressure, redrawn every cycle.
  always @(negedge clk_i) begin
    enc_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout with %0d encoded bytes outstanding", $time, pending_enc.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // Predicts on every source transfer and checks every encoded transfer.
  always @(posedge clk_i) begin : scoreboard
    enc_byte_t want;
    logic [16:0] utf;
    if (rst_ni) begin
      if (src_ch.valid && src_ch.ready) begin
        queue_encoding(src_ch.in_byte);
        utf = utf8_of(src_ch.in_byte);
        src_count++;
        if (utf[16]) accent_count++;
      end
      if (enc_ch.valid && enc_ch.ready) begin
        enc_count++;
        if (pending_enc.size() == 0) begin
          error_count++;
          $display("%0t: unexpected transfer, expected none, actual out_byte %h last %b",
                   $time, enc_ch.out_byte, enc_ch.last_of_run);
        end else begin
          want = pending_enc.pop_front();
          if (enc_ch.out_byte !== want.data) begin
            error_count++;
            $display("%0t: out_byte mismatch, expected %h, actual %h",
                     $time, want.data, enc_ch.out_byte);
          end
          if (enc_ch.last_of_run !== want.last) begin
            error_count++;
            $display("%0t: last_of_run mismatch, expected %b, actual %b",
                     $time, want.last, enc_ch.last_of_run);
          end
        end
      end
    end
  end

  // Offers one source byte, after random idle cycles, and waits for its transfer.
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      src_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    src_ch.valid   <= 1'b1;
    src_ch.in_byte <= b;
    @(posedge clk_i);
    while (!src_ch.ready) @(posedge clk_i);
  endtask

  // Stops offering bytes and waits until every queued run has left.
  task automatic drain_output();
    @(negedge clk_i);
    src_ch.valid <= 1'b0;
    while (pending_enc.size() != 0) @(posedge clk_i);
  endtask

  // Class boundaries, the marks, escaped punctuation, zero and high bytes.
  task automatic test_boundary_bytes();
    logic [7:0] boundary_bytes [25] = '{
      8'h00, 8'hFF, 8'h20, 8'h30, 8'h39, 8'h41, 8'h5A, 8'h61, 8'h7A,
      8'h7E, 8'h21, 8'h2A, 8'h28, 8'h29, 8'h27, 8'h2D, 8'h2E, 8'h5F,
      8'h2F, 8'h7F, 8'h80, 8'hE1, 8'hF5, 8'hDB, 8'hFE};
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    foreach (boundary_bytes[i]) send_byte(boundary_bytes[i]);
    // Let the encoder run dry before the random traffic starts.
    drain_output();
  endtask

  // Random source text under one mix of sender and receiver idling.
  task automatic test_random_text(input int unsigned n, input int unsigned idle_pct,
                                  input int unsigned stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n) send_byte(random_source_byte());
  endtask

  initial begin
    rst_ni         = 1'b0;
    src_ch.valid   = 1'b0;
    src_ch.in_byte = 8'h00;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_boundary_bytes();
    test_random_text(40, 0, 0);
    test_random_text(40, 82, 0);
    test_random_text(40, 0, 82);
    test_random_text(40, 29, 29);

    // Wait for the tail and watch for stray transfers.
    drain_output();
    repeat (SettleCycles) @(posedge clk_i);

    $display("Encoded %0d source bytes (%0d accented letters) into %0d output transfers,",
             src_count, accent_count, enc_count);
    $display("with sender gaps and receiver stalls each on, off and combined.");
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
